// ----- design/bqnm_pkg.sv -----
// Shared types, constants and tables for the biquad notch and sine mixer.
package bqnm_pkg;

    localparam int ADC_W          = 10;
    localparam int X_W            = 8;
    localparam int X_SHIFT        = 8;
    localparam int COEF_W         = 16;
    localparam int STATE_W        = 32;
    localparam int COEF_FRAC_BITS = 14;
    localparam int PROD_FRAC_BITS = 23;
    localparam int BYTE_W         = 8;
    localparam int TABLE_LEN      = 50;
    localparam int ROM_DEPTH      = 64;
    localparam int PHASE_W        = 6;
    localparam int CFG_IDX_W      = 3;

    localparam int DIGIT_W = 4;
    localparam int NDIG    = COEF_W / DIGIT_W;
    localparam int CNT_W   = $clog2(NDIG);
    localparam int MC_W    = STATE_W + COEF_W - DIGIT_W;
    localparam int PP_W    = MC_W + DIGIT_W + 1;
    localparam int ACC_W   = 50;
    localparam int SAT_W   = 38;

    localparam logic [CFG_IDX_W-1:0] REG_FF_COEF0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FF_COEF1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FF_COEF2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FB_COEF1 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FB_COEF2 = 3'd4;

    localparam logic signed [COEF_W-1:0] FF_COEF0_RST = 16'sd16384;
    localparam logic signed [COEF_W-1:0] FF_COEF1_RST = -16'sd17626;
    localparam logic signed [COEF_W-1:0] FF_COEF2_RST = 16'sd16384;
    localparam logic signed [COEF_W-1:0] FB_COEF1_RST = -16'sd16869;
    localparam logic signed [COEF_W-1:0] FB_COEF2_RST = 16'sd14977;

    localparam logic signed [COEF_W-1:0] SINE_ROM [ROM_DEPTH] = '{
        16'sd0,      16'sd25248,  16'sd32188,  16'sd15786,
        -16'sd12063, -16'sd31164, -16'sd27667, -16'sd4107,
        16'sd22431,  16'sd32703,  16'sd19261,  -16'sd8149,
        -16'sd29649, -16'sd29649, -16'sd8149,  16'sd19261,
        16'sd32703,  16'sd22431,  -16'sd4107,  -16'sd27667,
        -16'sd31164, -16'sd12063, 16'sd15786,  16'sd32188,
        16'sd25248,  16'sd0,      -16'sd25248, -16'sd32188,
        -16'sd15786, 16'sd12063,  16'sd31164,  16'sd27667,
        16'sd4107,   -16'sd22431, -16'sd32703, -16'sd19261,
        16'sd8149,   16'sd29649,  16'sd29649,  16'sd8149,
        -16'sd19261, -16'sd32703, -16'sd22431, 16'sd4107,
        16'sd27667,  16'sd31164,  16'sd12063,  -16'sd15786,
        -16'sd32188, -16'sd25248, 16'sd0,      16'sd0,
        16'sd0,      16'sd0,      16'sd0,      16'sd0,
        16'sd0,      16'sd0,      16'sd0,      16'sd0,
        16'sd0,      16'sd0,      16'sd0,      16'sd0
    };

    typedef struct packed {
        logic signed [COEF_W-1:0] ff0;
        logic signed [COEF_W-1:0] ff1;
        logic signed [COEF_W-1:0] ff2;
        logic signed [COEF_W-1:0] fb1;
        logic signed [COEF_W-1:0] fb2;
    } coef_set_t;

    typedef struct packed {
        logic                      start;
        logic                      clr;
        logic signed [STATE_W-1:0] mcand;
        logic        [COEF_W-1:0]  mplier;
    } mac_cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FB1,
        ST_FB2,
        ST_W0,
        ST_FF0,
        ST_FF1,
        ST_FF2,
        ST_Y,
        ST_MIX,
        ST_OUT
    } bqnm_state_t;

    function automatic logic signed [STATE_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
        logic [SAT_W-STATE_W:0] top;
        top = v[SAT_W-1:STATE_W-1];
        if ((&top) || !(|top)) begin
            return v[STATE_W-1:0];
        end else if (v[SAT_W-1]) begin
            return {1'b1, {(STATE_W-1){1'b0}}};
        end else begin
            return {1'b0, {(STATE_W-1){1'b1}}};
        end
    endfunction

endpackage

// ----- design/bqnm_coef_regs.sv -----
// Coefficient register file written through the configuration port.
module bqnm_coef_regs (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [bqnm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bqnm_pkg::COEF_W-1:0]     cfg_wdata,
    output bqnm_pkg::coef_set_t             coefs
);
    import bqnm_pkg::*;

    coef_set_t coef_reg;
    coef_set_t coef_next;

    always_comb begin
        coef_next = coef_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_FF_COEF0: coef_next.ff0 = cfg_wdata;
                REG_FF_COEF1: coef_next.ff1 = cfg_wdata;
                REG_FF_COEF2: coef_next.ff2 = cfg_wdata;
                REG_FB_COEF1: coef_next.fb1 = cfg_wdata;
                REG_FB_COEF2: coef_next.fb2 = cfg_wdata;
                default:      coef_next = coef_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg.ff0 <= FF_COEF0_RST;
            coef_reg.ff1 <= FF_COEF1_RST;
            coef_reg.ff2 <= FF_COEF2_RST;
            coef_reg.fb1 <= FB_COEF1_RST;
            coef_reg.fb2 <= FB_COEF2_RST;
        end else begin
            coef_reg <= coef_next;
        end
    end

    assign coefs = coef_reg;

endmodule

// ----- design/bqnm_mac.sv -----
// Digit-serial multiply-accumulate: 4-bit multiplier digit per cycle, LSB first.
module bqnm_mac (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  bqnm_pkg::mac_cmd_t                 cmd,
    output logic                               done,
    output logic signed [bqnm_pkg::ACC_W-1:0]  acc
);
    import bqnm_pkg::*;

    logic                    busy_reg, busy_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic signed [MC_W-1:0]  mcand_reg, mcand_next;
    logic [COEF_W-1:0]       mplier_reg, mplier_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [DIGIT_W:0] digit;
    logic signed [PP_W-1:0]  pp;
    logic                    last;

    assign last = (cnt_reg == CNT_W'(NDIG - 1));
    assign done = busy_reg && last;

    // top digit carries the sign of the coefficient
    assign digit = last ? {mplier_reg[DIGIT_W-1], mplier_reg[DIGIT_W-1:0]}
                        : {1'b0, mplier_reg[DIGIT_W-1:0]};
    assign pp    = mcand_reg * digit;

    always_comb begin
        busy_next   = busy_reg;
        cnt_next    = cnt_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        acc_next    = acc_reg;
        if (busy_reg) begin
            acc_next    = acc_reg + ACC_W'(pp);
            mcand_next  = mcand_reg <<< DIGIT_W;
            mplier_next = mplier_reg >> DIGIT_W;
            cnt_next    = cnt_reg + 1'b1;
            if (last) begin
                busy_next = 1'b0;
            end
        end
        if (cmd.start) begin
            busy_next   = 1'b1;
            cnt_next    = '0;
            mcand_next  = MC_W'(cmd.mcand);
            mplier_next = cmd.mplier;
            if (cmd.clr) begin
                acc_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        acc_reg    <= acc_next;
    end

    assign acc = acc_reg;

endmodule

// ----- design/biquad_notch_sine_mixer.sv -----
// Top level: sequencer, filter state, sine phase and output register of the notch mixer.
// One sample in, one byte out. Between one acceptance and the next, six 16-by-32 products
// (two feedback, three feed-forward, one sine mix) pass through a single multiply-accumulate
// unit at one 4-bit coefficient digit per cycle, plus a state each to saturate w0, saturate
// y, write the output and return to idle. A result waiting at the output does not block
// the next sample; only the final write waits for it.
// Coefficient writes take effect at once and belong between samples.
module biquad_notch_sine_mixer (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [bqnm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bqnm_pkg::COEF_W-1:0]     cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [bqnm_pkg::ADC_W-1:0]      s_adc_sample,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [bqnm_pkg::BYTE_W-1:0]     m_port_byte,
    output logic                            m_clipped
);
    import bqnm_pkg::*;

    localparam int HI_W = ACC_W - PROD_FRAC_BITS;

    coef_set_t               coefs;
    mac_cmd_t                mac_cmd;
    logic                    mac_done;
    logic signed [ACC_W-1:0] mac_acc;

    bqnm_state_t state_reg, state_next;

    logic [X_W-1:0]            x_reg, x_next;
    logic signed [STATE_W-1:0] w0_reg, w0_next;
    logic signed [STATE_W-1:0] delay_one_reg, delay_one_next;
    logic signed [STATE_W-1:0] delay_two_reg, delay_two_next;
    logic [PHASE_W-1:0]        phase_reg, phase_next;
    logic                      m_valid_reg, m_valid_next;
    logic [BYTE_W-1:0]         byte_reg, byte_next;
    logic                      clip_reg, clip_next;

    logic signed [SAT_W-1:0]   w0_diff;
    logic signed [STATE_W-1:0] w0_calc;
    logic signed [STATE_W-1:0] y_calc;
    logic                      out_free;
    logic                      accept;
    logic                      write_out;

    logic [HI_W-1:0]           prod_hi;
    logic                      prod_lo_nz;
    logic [BYTE_W-1:0]         res_byte;
    logic                      res_clip;

    bqnm_coef_regs u_coef_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .coefs     (coefs)
    );

    bqnm_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (mac_cmd),
        .done    (mac_done),
        .acc     (mac_acc)
    );

    // w0 = x*256 - floor(fb_sum / 2^14), y = floor(ff_sum / 2^14), both saturated
    assign w0_diff = $signed({{(SAT_W - X_W - X_SHIFT){1'b0}}, x_reg, {X_SHIFT{1'b0}}})
                   - SAT_W'(mac_acc >>> COEF_FRAC_BITS);
    assign w0_calc = sat32(w0_diff);
    assign y_calc  = sat32(SAT_W'(mac_acc >>> COEF_FRAC_BITS));

    // truncate toward zero, clamp to a byte
    assign prod_hi    = mac_acc[ACC_W-1:PROD_FRAC_BITS];
    assign prod_lo_nz = |mac_acc[PROD_FRAC_BITS-1:0];

    always_comb begin
        res_byte = prod_hi[BYTE_W-1:0];
        res_clip = 1'b0;
        if (mac_acc[ACC_W-1]) begin
            res_byte = '0;
            res_clip = !((&prod_hi) && prod_lo_nz);
        end else if (|prod_hi[HI_W-1:BYTE_W]) begin
            res_byte = '1;
            res_clip = 1'b1;
        end
    end

    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign write_out = (state_reg == ST_OUT) && out_free;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_valid)  state_next = ST_FB1;
            ST_FB1:  if (mac_done) state_next = ST_FB2;
            ST_FB2:  if (mac_done) state_next = ST_W0;
            ST_W0:                 state_next = ST_FF0;
            ST_FF0:  if (mac_done) state_next = ST_FF1;
            ST_FF1:  if (mac_done) state_next = ST_FF2;
            ST_FF2:  if (mac_done) state_next = ST_Y;
            ST_Y:                  state_next = ST_MIX;
            ST_MIX:  if (mac_done) state_next = ST_OUT;
            ST_OUT:  if (out_free) state_next = ST_IDLE;
            default:               state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        mac_cmd.start  = 1'b0;
        mac_cmd.clr    = 1'b0;
        mac_cmd.mcand  = delay_one_reg;
        mac_cmd.mplier = coefs.fb1;
        unique case (state_reg)
            ST_IDLE: begin
                mac_cmd.start  = s_valid;
                mac_cmd.clr    = 1'b1;
            end
            ST_FB1: begin
                mac_cmd.start  = mac_done;
                mac_cmd.mcand  = delay_two_reg;
                mac_cmd.mplier = coefs.fb2;
            end
            ST_W0: begin
                mac_cmd.start  = 1'b1;
                mac_cmd.clr    = 1'b1;
                mac_cmd.mcand  = w0_calc;
                mac_cmd.mplier = coefs.ff0;
            end
            ST_FF0: begin
                mac_cmd.start  = mac_done;
                mac_cmd.mcand  = delay_one_reg;
                mac_cmd.mplier = coefs.ff1;
            end
            ST_FF1: begin
                mac_cmd.start  = mac_done;
                mac_cmd.mcand  = delay_two_reg;
                mac_cmd.mplier = coefs.ff2;
            end
            ST_Y: begin
                mac_cmd.start  = 1'b1;
                mac_cmd.clr    = 1'b1;
                mac_cmd.mcand  = y_calc;
                mac_cmd.mplier = SINE_ROM[phase_reg];
            end
            default: begin
                mac_cmd.start  = 1'b0;
            end
        endcase
    end

    always_comb begin
        x_next         = x_reg;
        w0_next        = w0_reg;
        delay_one_next = delay_one_reg;
        delay_two_next = delay_two_reg;
        phase_next     = phase_reg;
        m_valid_next   = m_valid_reg;
        byte_next      = byte_reg;
        clip_next      = clip_reg;
        if (accept) begin
            x_next = s_adc_sample[ADC_W-1:ADC_W-X_W];
        end
        if (state_reg == ST_W0) begin
            w0_next = w0_calc;
        end
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (write_out) begin
            m_valid_next   = 1'b1;
            byte_next      = res_byte;
            clip_next      = res_clip;
            delay_two_next = delay_one_reg;
            delay_one_next = w0_reg;
            phase_next     = (phase_reg == PHASE_W'(TABLE_LEN - 1)) ? '0 : phase_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            delay_one_reg <= '0;
            delay_two_reg <= '0;
            phase_reg     <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            delay_one_reg <= delay_one_next;
            delay_two_reg <= delay_two_next;
            phase_reg     <= phase_next;
            m_valid_reg   <= m_valid_next;
        end
        x_reg    <= x_next;
        w0_reg   <= w0_next;
        byte_reg <= byte_next;
        clip_reg <= clip_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_port_byte = byte_reg;
    assign m_clipped   = clip_reg;

endmodule
